// ----- src/rts_pkg.sv -----
// shared types and constants for the rtf token scanner
package rts_pkg;

  localparam int PARAM_BITS_DEF = 32;
  localparam int RES_DEPTH = 4;

  typedef enum logic [3:0] {
    M_START,
    M_TEXT,
    M_BSLASH,
    M_WORD,
    M_WORD_OTHER,
    M_NEG,
    M_DIGITS,
    M_HEX1,
    M_HEX2,
    M_BIN
  } mode_t;

  localparam logic [2:0] TT_OPEN  = 3'd0;
  localparam logic [2:0] TT_CLOSE = 3'd1;
  localparam logic [2:0] TT_CTRL  = 3'd2;
  localparam logic [2:0] TT_TEXT  = 3'd3;
  localparam logic [2:0] TT_BIN   = 3'd4;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [1:0] BIN_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]  tok_type;
    logic [7:0]  text;
    logic        tok_end;
    logic        has_param;
    logic [31:0] param;
    logic        last;
  } res_t;

  function automatic res_t mk_res(logic [2:0] tt, logic [7:0] tx, logic te,
                                  logic hp, logic [31:0] pv);
    res_t r;
    r.tok_type  = tt;
    r.text      = tx;
    r.tok_end   = te;
    r.has_param = hp;
    r.param     = pv;
    r.last      = 1'b0;
    return r;
  endfunction

  // letters of "bin" in match order
  function automatic logic [7:0] bin_char(logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h62;
      2'd1:    c = 8'h69;
      2'd2:    c = 8'h6e;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic logic [3:0] nibble(logic [7:0] b);
    return b[3:0] + (b[4] ? 4'd0 : 4'd9);
  endfunction

endpackage

// ----- src/rtf_token_scanner_unit.sv -----
// rtf token scanner top level: byte scanner state and result queue
//
//  channel  handshake           payload
//  in       in_valid/in_ready   data_byte, end_of_input
//  out      out_valid/out_ready token_type, text_byte, token_end, has_param,
//                               param_value, last
//
// each word is decoded in the cycle it is taken; its zero to two results go into a
// four-entry queue; from an empty queue the first shows on the output next cycle.
// in_ready is high while the queue has room for two results; with out_ready high a
// word is taken every cycle unless two-result words come back to back faster than
// the one-result-a-cycle output drains them, then in_ready drops for a cycle.
// synchronous reset returns the scanner to token start and empties the queue.
module rtf_token_scanner_unit #(
  parameter int PARAM_BITS = rts_pkg::PARAM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               end_of_input,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         token_type,
  output logic [7:0]         text_byte,
  output logic               token_end,
  output logic               has_param,
  output logic signed [31:0] param_value,
  output logic               last
);

  localparam int PW = $clog2(rts_pkg::RES_DEPTH);
  localparam int CW = $clog2(rts_pkg::RES_DEPTH + 1);

  rts_pkg::mode_t  mode, mode_next;
  logic [1:0]      bin_step, bin_step_next;
  logic [PARAM_BITS-1:0] acc, acc_next;
  logic            neg, neg_next;
  logic            seen, seen_next;
  logic [7:0]      hex, hex_next;
  logic [31:0]     remain, remain_next;

  rts_pkg::res_t   res [2];
  logic [1:0]      nres;

  rts_pkg::res_t   queue [rts_pkg::RES_DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  logic [PARAM_BITS-1:0] pv_raw;
  logic signed [63:0]    pv_ext;
  logic [31:0]           pval;
  logic [3:0]            digit;
  logic [3:0]            nib;

  logic            push, pop;
  logic            do_start, do_bin;
  logic [31:0]     bin_cnt;
  logic [31:0]     wval;
  logic [7:0]      b;

  assign b      = data_byte;
  assign digit  = 4'(data_byte - rts_pkg::CH_ZERO);
  assign nib    = rts_pkg::nibble(data_byte);
  assign pv_raw = neg ? (PARAM_BITS'(0) - acc) : acc;
  assign pv_ext = 64'(signed'(pv_raw));
  assign pval   = pv_ext[31:0];

  always_comb begin
    mode_next     = mode;
    bin_step_next = bin_step;
    acc_next      = acc;
    neg_next      = neg;
    seen_next     = seen;
    hex_next      = hex;
    remain_next   = remain;
    res[0]        = '0;
    res[1]        = '0;
    nres          = 2'd0;
    do_start      = 1'b0;
    do_bin        = 1'b0;
    bin_cnt       = remain;
    wval          = seen ? pval : 32'd0;

    if (end_of_input) begin
      unique case (mode)
        rts_pkg::M_TEXT: begin
          res[nres[0]] = rts_pkg::mk_res(rts_pkg::TT_TEXT, 8'd0, 1'b1, 1'b0, 32'd0);
          nres = nres + 2'd1;
        end
        rts_pkg::M_WORD, rts_pkg::M_WORD_OTHER, rts_pkg::M_NEG, rts_pkg::M_DIGITS: begin
          res[nres[0]] = rts_pkg::mk_res(rts_pkg::TT_CTRL, 8'd0, 1'b1, seen, wval);
          nres = nres + 2'd1;
        end
        rts_pkg::M_HEX2: begin
          res[nres[0]] = rts_pkg::mk_res(rts_pkg::TT_CTRL, rts_pkg::CH_QUOTE, 1'b1, 1'b1,
                                         {24'd0, hex});
          nres = nres + 2'd1;
        end
        rts_pkg::M_BIN: begin
          res[nres[0]] = rts_pkg::mk_res(rts_pkg::TT_BIN, 8'd0, 1'b1, 1'b0, remain);
          nres = nres + 2'd1;
        end
        default: ;
      endcase
      res[nres[0]] = rts_pkg::mk_res(rts_pkg::TT_CLOSE, 8'd0, 1'b1, 1'b0, 32'd0);
      nres = nres + 2'd1;
      mode_next     = rts_pkg::M_START;
      bin_step_next = 2'd0;
      acc_next      = '0;
      neg_next      = 1'b0;
      seen_next     = 1'b0;
      hex_next      = 8'd0;
      remain_next   = 32'd0;
    end else begin
      unique case (mode)
        rts_pkg::M_TEXT: begin
          if (b == rts_pkg::CH_BSLASH || b == rts_pkg::CH_LBRACE ||
              b == rts_pkg::CH_RBRACE || b == rts_pkg::CH_CR || b == rts_pkg::CH_LF) begin
            res[nres[0]] = rts_pkg::mk_res(rts_pkg::TT_TEXT, 8'd0, 1'b1, 1'b0, 32'd0);
            nres = nres + 2'd1;
            mode_next = rts_pkg::M_START;
            do_start  = 1'b1;
          end else begin
            res[nres[0]] = rts_pkg::mk_res(rts_pkg::TT_TEXT, b, 1'b0, 1'b0, 32'd0);
            nres = nres + 2'd1;
          end
        end
        rts_pkg::M_BSLASH: begin
          bin_step_next = 2'd0;
          acc_next      = '0;
          neg_next      = 1'b0;
          seen_next     = 1'b0;
          hex_next      = 8'd0;
          if (rts_pkg::is_letter(b)) begin
            if (b == rts_pkg::bin_char(2'd0)) begin
              bin_step_next = 2'd1;
              mode_next     = rts_pkg::M_WORD;
            end else begin
              mode_next = rts_pkg::M_WORD_OTHER;
            end
            res[nres[0]] = rts_pkg::mk_res(rts_pkg::TT_CTRL, b, 1'b0, 1'b0, 32'd0);
            nres = nres + 2'd1;
          end else if (b == rts_pkg::CH_QUOTE) begin
            mode_next = rts_pkg::M_HEX1;
          end else begin
            res[nres[0]] = rts_pkg::mk_res(rts_pkg::TT_CTRL, b, 1'b1, 1'b0, 32'd0);
            nres = nres + 2'd1;
            mode_next = rts_pkg::M_START;
          end
        end
        rts_pkg::M_WORD, rts_pkg::M_WORD_OTHER, rts_pkg::M_NEG, rts_pkg::M_DIGITS: begin
          if ((mode == rts_pkg::M_WORD || mode == rts_pkg::M_WORD_OTHER) &&
              rts_pkg::is_letter(b)) begin
            if (mode == rts_pkg::M_WORD && bin_step != rts_pkg::BIN_FULL &&
                b == rts_pkg::bin_char(bin_step)) begin
              bin_step_next = bin_step + 2'd1;
            end else begin
              bin_step_next = 2'd0;
              mode_next     = rts_pkg::M_WORD_OTHER;
            end
            res[nres[0]] = rts_pkg::mk_res(rts_pkg::TT_CTRL, b, 1'b0, 1'b0, 32'd0);
            nres = nres + 2'd1;
          end else if ((mode == rts_pkg::M_WORD || mode == rts_pkg::M_WORD_OTHER) &&
                       b == rts_pkg::CH_MINUS) begin
            neg_next  = 1'b1;
            mode_next = rts_pkg::M_NEG;
          end else if (rts_pkg::is_digit(b)) begin
            // first digit loads, later digits shift in by times ten
            if (mode == rts_pkg::M_WORD || mode == rts_pkg::M_WORD_OTHER) begin
              acc_next = PARAM_BITS'(digit);
            end else begin
              acc_next = (acc << 3) + (acc << 1) + PARAM_BITS'(digit);
            end
            seen_next = 1'b1;
            mode_next = rts_pkg::M_DIGITS;
          end else begin
            // control word ends here
            res[nres[0]] = rts_pkg::mk_res(rts_pkg::TT_CTRL, 8'd0, 1'b1, seen, wval);
            nres = nres + 2'd1;
            bin_step_next = 2'd0;
            acc_next      = '0;
            neg_next      = 1'b0;
            seen_next     = 1'b0;
            hex_next      = 8'd0;
            if (bin_step == rts_pkg::BIN_FULL && seen && wval != 32'd0 && !wval[31]) begin
              remain_next = wval;
              bin_cnt     = wval;
              mode_next   = rts_pkg::M_BIN;
              do_bin      = (b != rts_pkg::CH_SPACE);
            end else begin
              mode_next = rts_pkg::M_START;
              do_start  = (b != rts_pkg::CH_SPACE);
            end
          end
        end
        rts_pkg::M_HEX1: begin
          hex_next  = {4'd0, nib};
          mode_next = rts_pkg::M_HEX2;
        end
        rts_pkg::M_HEX2: begin
          res[nres[0]] = rts_pkg::mk_res(rts_pkg::TT_CTRL, rts_pkg::CH_QUOTE, 1'b1, 1'b1,
                                         {24'd0, hex[3:0], nib});
          nres = nres + 2'd1;
          bin_step_next = 2'd0;
          acc_next      = '0;
          neg_next      = 1'b0;
          seen_next     = 1'b0;
          hex_next      = 8'd0;
          mode_next     = rts_pkg::M_START;
        end
        rts_pkg::M_BIN: begin
          do_bin = 1'b1;
        end
        default: begin
          mode_next = rts_pkg::M_START;
          do_start  = 1'b1;
        end
      endcase

      if (do_start) begin
        priority if (b == rts_pkg::CH_LBRACE) begin
          res[nres[0]] = rts_pkg::mk_res(rts_pkg::TT_OPEN, 8'd0, 1'b1, 1'b0, 32'd0);
          nres = nres + 2'd1;
        end else if (b == rts_pkg::CH_RBRACE) begin
          res[nres[0]] = rts_pkg::mk_res(rts_pkg::TT_CLOSE, 8'd0, 1'b1, 1'b0, 32'd0);
          nres = nres + 2'd1;
        end else if (b == rts_pkg::CH_BSLASH) begin
          mode_next = rts_pkg::M_BSLASH;
        end else if (b == rts_pkg::CH_CR || b == rts_pkg::CH_LF) begin
          mode_next = rts_pkg::M_START;
        end else begin
          mode_next = rts_pkg::M_TEXT;
          res[nres[0]] = rts_pkg::mk_res(rts_pkg::TT_TEXT, b, 1'b0, 1'b0, 32'd0);
          nres = nres + 2'd1;
        end
      end

      if (do_bin) begin
        res[nres[0]] = rts_pkg::mk_res(rts_pkg::TT_BIN, b, bin_cnt == 32'd1, 1'b0, bin_cnt);
        nres = nres + 2'd1;
        remain_next = bin_cnt - 32'd1;
        if (bin_cnt == 32'd1) begin
          mode_next = rts_pkg::M_START;
        end
      end
    end

    if (nres == 2'd1) begin
      res[0].last = 1'b1;
    end else if (nres == 2'd2) begin
      res[1].last = 1'b1;
    end
  end

  assign in_ready = (count <= CW'(rts_pkg::RES_DEPTH - 2));
  assign push     = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= rts_pkg::M_START;
      bin_step <= 2'd0;
      acc      <= '0;
      neg      <= 1'b0;
      seen     <= 1'b0;
      hex      <= 8'd0;
      remain   <= 32'd0;
    end else if (push) begin
      mode     <= mode_next;
      bin_step <= bin_step_next;
      acc      <= acc_next;
      neg      <= neg_next;
      seen     <= seen_next;
      hex      <= hex_next;
      remain   <= remain_next;
    end
  end

  // result queue, up to two words written per accepted input
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(nres);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (push ? CW'(nres) : CW'(0)) - (pop ? CW'(1) : CW'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (push && nres != 2'd0) begin
      queue[wr_ptr] <= res[0];
    end
    if (push && nres == 2'd2) begin
      queue[wr_ptr + PW'(1)] <= res[1];
    end
  end

  assign token_type  = queue[rd_ptr].tok_type;
  assign text_byte   = queue[rd_ptr].text;
  assign token_end   = queue[rd_ptr].tok_end;
  assign has_param   = queue[rd_ptr].has_param;
  assign param_value = signed'(queue[rd_ptr].param);
  assign last        = queue[rd_ptr].last;

endmodule

// ----- src/rts_checker.sv -----
// port-level checks for the rtf token scanner, bound to the top level
module rts_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         token_type,
  input logic [7:0]         text_byte,
  input logic               token_end,
  input logic               has_param,
  input logic signed [31:0] param_value,
  input logic               last
);

  // a stalled output word keeps its type, text, parameter value and last flag
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_type) && $stable(text_byte)
      && $stable(param_value) && $stable(last))
    else $error("output word changed while stalled");

  a_type_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_type <= rts_pkg::TT_BIN)
    else $error("token type out of range");

  // group words are single complete pieces without text or parameter
  a_group_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_type == rts_pkg::TT_OPEN || token_type == rts_pkg::TT_CLOSE)
      |-> token_end && text_byte == 8'd0 && !has_param && param_value == 32'sd0)
    else $error("malformed group word");

  // binary pieces carry no parameter flag and a positive remaining count
  a_bin_param: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_type == rts_pkg::TT_BIN |-> !has_param && param_value > 32'sd0)
    else $error("binary word with bad remaining count");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind rtf_token_scanner_unit rts_checker u_rts_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .token_type  (token_type),
  .text_byte   (text_byte),
  .token_end   (token_end),
  .has_param   (has_param),
  .param_value (param_value),
  .last        (last)
);

// ----- tb/rts_token_checker.sv -----
// token predictor and result checker for the rtf token scanner
module rts_token_checker
  import rts_pkg::*;
#(
  parameter int PBITS = PARAM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               end_of_input,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         token_type,
  input  logic [7:0]         text_byte,
  input  logic               token_end,
  input  logic               has_param,
  input  logic signed [31:0] param_value,
  input  logic               last,
  output int                 fail_count,
  output int                 words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] PMASK = (64'd1 << PBITS) - 64'd1;
  localparam logic [23:0] BIN_TXT = "bin";
  localparam int REPORT_MAX = 100;

  mode_t       scan_st;
  logic [1:0]  bin_step;
  logic [63:0] acc;
  logic        neg;
  logic        seen;
  logic [7:0]  hex_acc;
  logic [31:0] bin_left;
  res_t        expected_tokens[$];
  res_t        want;

  function automatic logic alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic numeral(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  // any byte counts as a hex digit
  function automatic logic [3:0] hex_nib(logic [7:0] b);
    return b[4] ? b[3:0] : b[3:0] + 4'd9;
  endfunction

  function automatic void push_tok(logic [2:0] tt, logic [7:0] tx, logic te, logic hp,
                                   logic [31:0] pv);
    res_t r;
    r.tok_type  = tt;
    r.text      = tx;
    r.tok_end   = te;
    r.has_param = hp;
    r.param     = pv;
    r.last      = 1'b0;
    expected_tokens.push_back(r);
  endfunction

  function automatic logic [31:0] param32();
    logic [63:0] v;
    v = acc & PMASK;
    if (neg) v = (64'd0 - v) & PMASK;
    if (PBITS < 32 && v[PBITS-1]) v = v | ~PMASK;
    return v[31:0];
  endfunction

  function automatic void clear_tok();
    bin_step = 2'd0;
    acc      = 64'd0;
    neg      = 1'b0;
    seen     = 1'b0;
    hex_acc  = 8'd0;
  endfunction

  function automatic void start_char(logic [7:0] b);
    if (b == CH_LBRACE) begin
      push_tok(TT_OPEN, 8'd0, 1'b1, 1'b0, 32'd0);
    end else if (b == CH_RBRACE) begin
      push_tok(TT_CLOSE, 8'd0, 1'b1, 1'b0, 32'd0);
    end else if (b == CH_BSLASH) begin
      scan_st = M_BSLASH;
    end else if (b != CH_CR && b != CH_LF) begin
      scan_st = M_TEXT;
      push_tok(TT_TEXT, b, 1'b0, 1'b0, 32'd0);
    end
  endfunction

  function automatic void bin_data(logic [7:0] b);
    push_tok(TT_BIN, b, bin_left == 32'd1, 1'b0, bin_left);
    bin_left = bin_left - 32'd1;
    if (bin_left == 32'd0) scan_st = M_START;
  endfunction

  // delimiter after a control word: may open binary data or start a new token
  function automatic void finish_ctrl(logic [7:0] b);
    logic [31:0] v;
    logic        go_bin;
    v = seen ? param32() : 32'd0;
    push_tok(TT_CTRL, 8'd0, 1'b1, seen, v);
    go_bin = bin_step == BIN_FULL && seen && v != 32'd0 && !v[31];
    clear_tok();
    if (go_bin) begin
      bin_left = v;
      scan_st  = M_BIN;
      if (b != CH_SPACE) bin_data(b);
    end else begin
      scan_st = M_START;
      if (b != CH_SPACE) start_char(b);
    end
  endfunction

  task automatic predict_tokens(input logic [7:0] b, input logic eoi);
    int          first;
    logic [7:0]  dig;
    res_t        r;
    first = expected_tokens.size();
    dig = b - CH_ZERO;
    if (eoi) begin
      case (scan_st)
        M_TEXT: push_tok(TT_TEXT, 8'd0, 1'b1, 1'b0, 32'd0);
        M_WORD, M_WORD_OTHER, M_NEG, M_DIGITS:
          push_tok(TT_CTRL, 8'd0, 1'b1, seen, seen ? param32() : 32'd0);
        M_HEX2: push_tok(TT_CTRL, CH_QUOTE, 1'b1, 1'b1, {24'd0, hex_acc});
        M_BIN: push_tok(TT_BIN, 8'd0, 1'b1, 1'b0, bin_left);
        default: ;
      endcase
      push_tok(TT_CLOSE, 8'd0, 1'b1, 1'b0, 32'd0);
      scan_st = M_START;
      clear_tok();
      bin_left = 32'd0;
    end else begin
      case (scan_st)
        M_TEXT: begin
          if (b == CH_BSLASH || b == CH_LBRACE || b == CH_RBRACE || b == CH_CR ||
              b == CH_LF) begin
            push_tok(TT_TEXT, 8'd0, 1'b1, 1'b0, 32'd0);
            scan_st = M_START;
            start_char(b);
          end else begin
            push_tok(TT_TEXT, b, 1'b0, 1'b0, 32'd0);
          end
        end
        M_BSLASH: begin
          clear_tok();
          if (alpha(b)) begin
            if (b == BIN_TXT[23:16]) begin
              bin_step = 2'd1;
              scan_st  = M_WORD;
            end else begin
              scan_st = M_WORD_OTHER;
            end
            push_tok(TT_CTRL, b, 1'b0, 1'b0, 32'd0);
          end else if (b == CH_QUOTE) begin
            scan_st = M_HEX1;
          end else begin
            push_tok(TT_CTRL, b, 1'b1, 1'b0, 32'd0);
            scan_st = M_START;
          end
        end
        M_WORD, M_WORD_OTHER: begin
          if (alpha(b)) begin
            // track whether the word so far is a prefix of "bin"
            if (scan_st == M_WORD && bin_step < BIN_FULL &&
                b == BIN_TXT[8*(2-bin_step) +: 8]) begin
              bin_step = bin_step + 2'd1;
            end else begin
              bin_step = 2'd0;
              scan_st  = M_WORD_OTHER;
            end
            push_tok(TT_CTRL, b, 1'b0, 1'b0, 32'd0);
          end else if (b == CH_MINUS) begin
            neg     = 1'b1;
            scan_st = M_NEG;
          end else if (numeral(b)) begin
            acc     = {56'd0, dig};
            seen    = 1'b1;
            scan_st = M_DIGITS;
          end else begin
            finish_ctrl(b);
          end
        end
        M_NEG, M_DIGITS: begin
          if (numeral(b)) begin
            acc     = (acc * 64'd10 + {56'd0, dig}) & PMASK;
            seen    = 1'b1;
            scan_st = M_DIGITS;
          end else begin
            finish_ctrl(b);
          end
        end
        M_HEX1: begin
          hex_acc = {4'd0, hex_nib(b)};
          scan_st = M_HEX2;
        end
        M_HEX2: begin
          hex_acc = {hex_acc[3:0], hex_nib(b)};
          push_tok(TT_CTRL, CH_QUOTE, 1'b1, 1'b1, {24'd0, hex_acc});
          clear_tok();
          scan_st = M_START;
        end
        M_BIN: bin_data(b);
        default: begin
          scan_st = M_START;
          start_char(b);
        end
      endcase
    end
    if (expected_tokens.size() > first) begin
      r = expected_tokens.pop_back();
      r.last = 1'b1;
      expected_tokens.push_back(r);
    end
  endtask

  function automatic void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      if (fail_count < REPORT_MAX)
        $error("%s: expected 'h%0h, actual 'h%0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      scan_st = M_START;
      clear_tok();
      bin_left = 32'd0;
      expected_tokens.delete();
    end else begin
      if (in_valid && in_ready) predict_tokens(data_byte, end_of_input);
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $error("unexpected word: token_type %0d text_byte 'h%0h", token_type, text_byte);
          fail_count++;
        end else begin
          want = expected_tokens.pop_front();
          cmp_field("token_type", {29'd0, want.tok_type}, {29'd0, token_type});
          cmp_field("text_byte", {24'd0, want.text}, {24'd0, text_byte});
          cmp_field("token_end", {31'd0, want.tok_end}, {31'd0, token_end});
          cmp_field("has_param", {31'd0, want.has_param}, {31'd0, has_param});
          cmp_field("param_value", want.param, param_value);
          cmp_field("last", {31'd0, want.last}, {31'd0, last});
        end
      end
    end
    words_pending = expected_tokens.size();
  end

endmodule

// ----- tb/testbench.sv -----
// stimulus, receiver stalls and verdict for the rtf token scanner
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rts_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int WORD_TARGET = 1700;

  typedef enum int {RX_OPEN, RX_BUSY, RX_SPARSE, RX_BEAT} rx_style_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         data_byte = 8'd0;
  logic               end_of_input = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         token_type;
  logic [7:0]         text_byte;
  logic               token_end;
  logic               has_param;
  logic signed [31:0] param_value;
  logic               last;

  int        fails;
  int        pending;
  int        cycles = 0;
  int        words_sent = 0;
  int        burst_left = 0;
  rx_style_t rx_style = RX_OPEN;
  int        rx_left = 0;
  int        rx_tick = 0;

  always #5 clk = ~clk;

  rtf_token_scanner_unit u_top (.*);

  rts_token_checker u_chk (
    .*,
    .fail_count(fails),
    .words_pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: switches between random stall styles
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 3));
      rx_left  = $urandom_range(30, 200);
    end
    rx_left--;
    rx_tick++;
    case (rx_style)
      RX_OPEN:   out_ready <= 1'b1;
      RX_BUSY:   out_ready <= $urandom_range(0, 3) != 0;
      RX_SPARSE: out_ready <= $urandom_range(0, 3) == 0;
      default:   out_ready <= (rx_tick % 5) != 0;
    endcase
  end

  // entered and left at a falling edge; bursts of words with random gaps
  task automatic send_word(input logic [7:0] b, input logic eoi);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 30) : $urandom_range(0, 2);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    end_of_input <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic send_ctrl_word();
    int         n;
    int         sel;
    logic [7:0] c;
    send_word(CH_BSLASH, 1'b0);
    sel = $urandom_range(0, 7);
    if (sel == 0) send_str("bi");
    else if (sel == 1) send_str("binx");
    else if (sel == 2) send_str("bbin");
    else if (sel == 3) send_str("b");
    else begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        c = 8'($urandom_range(0, 25));
        send_word($urandom_range(0, 1) ? c + "a" : c + "A", 1'b0);
      end
    end
    // none, minus alone, digits, or minus and digits
    sel = $urandom_range(0, 5);
    if (sel == 1 || sel == 5) send_word(CH_MINUS, 1'b0);
    if (sel >= 2) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
      repeat (n) send_word(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    end
    sel = $urandom_range(0, 3);
    if (sel < 2) send_word(CH_SPACE, 1'b0);
    else if (sel == 2) send_word(8'($urandom_range(0, 255)), 1'b0);
    else begin
      case ($urandom_range(0, 3))
        0:       send_word(CH_LBRACE, 1'b0);
        1:       send_word(CH_RBRACE, 1'b0);
        2:       send_word(CH_BSLASH, 1'b0);
        default: send_word(CH_CR, 1'b0);
      endcase
    end
  endtask

  task automatic send_binary();
    int         n;
    logic [7:0] c;
    send_word(CH_BSLASH, 1'b0);
    case ($urandom_range(0, 7))
      0: send_str("bin0 ");
      1: send_str($sformatf("bin-%0d ", $urandom_range(1, 9)));
      2: send_str("bin ");
      3: begin
        // huge count, cut short by end of input
        send_str("bin2147483647 ");
        repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)), 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end
      4: begin
        // count wraps to one
        send_str("bin4294967297 ");
        send_word(8'($urandom_range(0, 255)), 1'b0);
      end
      default: begin
        n = $urandom_range(1, 6);
        send_str($sformatf("bin%0d", n));
        if ($urandom_range(0, 1)) begin
          send_word(CH_SPACE, 1'b0);
        end else begin
          // delimiter doubles as the first data word
          case ($urandom_range(0, 4))
            0:       c = 8'h00;
            1:       c = 8'hff;
            2:       c = CH_LBRACE;
            3:       c = CH_LF;
            default: c = 8'h80 | 8'($urandom_range(0, 127));
          endcase
          send_word(c, 1'b0);
          n--;
        end
        repeat (n) send_word(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
  endtask

  task automatic send_fragment();
    int         pick;
    int         sel;
    string      hx;
    logic [7:0] c;
    hx = "0123456789abcdefABCDEF";
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_word(CH_LBRACE, 1'b0);
    end else if (pick < 16) begin
      send_word(CH_RBRACE, 1'b0);
    end else if (pick < 34) begin
      repeat ($urandom_range(1, 8)) begin
        c = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(32, 126));
        send_word(c, 1'b0);
      end
    end else if (pick < 56) begin
      send_ctrl_word();
    end else if (pick < 68) begin
      send_binary();
    end else if (pick < 76) begin
      send_word(CH_BSLASH, 1'b0);
      send_word(CH_QUOTE, 1'b0);
      repeat (2) begin
        c = $urandom_range(0, 1) ? hx[$urandom_range(0, 21)] : 8'($urandom_range(0, 255));
        send_word(c, 1'b0);
      end
    end else if (pick < 81) begin
      send_word(CH_BSLASH, 1'b0);
      send_word(8'($urandom_range(33, 64)), 1'b0);
    end else if (pick < 85) begin
      send_word($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
    end else if (pick < 89) begin
      send_word(8'($urandom_range(0, 255)), 1'b1);
    end else if (pick < 94) begin
      // token cut off by end of input
      sel = $urandom_range(0, 5);
      send_word(CH_BSLASH, 1'b0);
      case (sel)
        0: ;
        1: send_word(CH_QUOTE, 1'b0);
        2: begin
          send_word(CH_QUOTE, 1'b0);
          send_word(8'($urandom_range(0, 255)), 1'b0);
        end
        3: send_str("ab");
        4: send_str("x-4");
        default: send_str("q-");
      endcase
      send_word(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    bit drained;
    drained = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: groups, binary with a non-space delimiter, minus without digits,
    // raw hex digits, control symbol, skipped line breaks, lone backslash at the end
    send_word(CH_LBRACE, 1'b0);
    send_word(CH_BSLASH, 1'b0);
    send_str("bin2x");
    send_word(8'hff, 1'b0);
    send_word(CH_RBRACE, 1'b0);
    send_word(CH_BSLASH, 1'b0);
    send_str("w- ");
    send_word(CH_BSLASH, 1'b0);
    send_word(CH_QUOTE, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h7f, 1'b0);
    send_word(CH_BSLASH, 1'b0);
    send_str("~");
    send_word(CH_CR, 1'b0);
    send_word(CH_LF, 1'b0);
    send_str("A");
    send_word(8'h80, 1'b0);
    send_word(CH_BSLASH, 1'b0);
    send_word(8'hff, 1'b1);

    while (words_sent < WORD_TARGET) begin
      send_fragment();
      if (!drained && words_sent >= WORD_TARGET / 2) begin
        wait_drain();
        drained = 1'b1;
      end
    end
    send_word(8'($urandom_range(0, 255)), 1'b1);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/rts_pkg.sv
src/rtf_token_scanner_unit.sv
src/rts_checker.sv
tb/rts_token_checker.sv
tb/testbench.sv
